>>> rtl/dsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types, constants and character helpers for the string unescaper.
// ----------------------------------------------------------------------------
package dsu_pkg;

	localparam int unsigned COUNT_MAX_DEFAULT = 32'd65535;
	localparam logic [7:0]  DELIM_RESET       = 8'h22;

	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_X         = 8'h78;
	localparam logic [7:0] CH_A         = 8'h61;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_N         = 8'h6E;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_V         = 8'h76;

	typedef struct packed {
		logic        in_escape;
		logic        in_hex;
		logic        have_high_nibble;
		logic [3:0]  high_nibble;
		logic [15:0] consumed;
	} dsu_state_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        out_valid;
		logic        finished;
		logic        failed;
		logic [15:0] byte_count;
	} dsu_result_t;

	// Hex digit value; anything that is not a hex digit counts as zero.
	function automatic logic [3:0] hex_nibble(input logic [7:0] ch);
		logic [3:0] v;
		v = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			v = ch[3:0];
		end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
			v = 4'(ch[2:0] + 3'd1) + 4'd8;
		end
		return v;
	endfunction

	// Single-character escapes; any other character stands for itself.
	function automatic logic [7:0] escape_char(input logic [7:0] ch);
		logic [7:0] v;
		case (ch)
			CH_A:    v = 8'd7;
			CH_B:    v = 8'd8;
			CH_F:    v = 8'd12;
			CH_N:    v = 8'd10;
			CH_R:    v = 8'd13;
			CH_T:    v = 8'd9;
			CH_V:    v = 8'd11;
			default: v = ch;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/dsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsu_decode
// Next-state and result logic for one input word of the unescaper.
// ----------------------------------------------------------------------------
module dsu_decode #(
	parameter int unsigned COUNT_MAX = dsu_pkg::COUNT_MAX_DEFAULT
) (
	input  dsu_pkg::dsu_state_t  state,
	input  logic [7:0]           delimiter,
	input  logic [7:0]           in_byte,
	input  logic                 stream_end,
	output dsu_pkg::dsu_state_t  state_next,
	output dsu_pkg::dsu_result_t result
);
	import dsu_pkg::*;

	localparam logic [15:0] CountLimit =
		(COUNT_MAX < 32'd65535) ? 16'(COUNT_MAX) : 16'hFFFF;

	logic [15:0] count_inc;
	logic [3:0]  nib;

	assign count_inc = (state.consumed < CountLimit) ? state.consumed + 16'd1
		: state.consumed;
	assign nib = hex_nibble(in_byte);

	always_comb begin
		state_next = state;
		result     = '0;
		if (stream_end) begin
			result.finished = 1'b1;
			result.failed   = 1'b1;
			state_next      = '0;
		end else begin
			state_next.consumed = count_inc;
			if (state.in_escape) begin
				if (state.in_hex) begin
					if (state.have_high_nibble) begin
						result.out_byte  = {state.high_nibble, nib};
						result.out_valid = 1'b1;
						state_next.in_escape        = 1'b0;
						state_next.in_hex           = 1'b0;
						state_next.have_high_nibble = 1'b0;
						state_next.high_nibble      = 4'd0;
					end else begin
						state_next.high_nibble      = nib;
						state_next.have_high_nibble = 1'b1;
					end
				end else if (in_byte == CH_X) begin
					state_next.in_hex = 1'b1;
				end else begin
					result.out_byte      = escape_char(in_byte);
					result.out_valid     = 1'b1;
					state_next.in_escape = 1'b0;
				end
			end else if (in_byte == CH_BACKSLASH) begin
				state_next.in_escape = 1'b1;
			end else if (in_byte == delimiter) begin
				result.finished   = 1'b1;
				result.byte_count = count_inc;
				state_next        = '0;
			end else begin
				result.out_byte  = in_byte;
				result.out_valid = 1'b1;
			end
		end
	end

endmodule

>>> rtl/delimited_string_unescaper_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delimited_string_unescaper_top
// Decodes escape sequences of a quoted string, one result word per input word.
// ----------------------------------------------------------------------------
// Output: the result word is registered and is on the outputs in the cycle after input acceptance.
// Throughput: one word per cycle; the single result register is refilled in
// the cycle it is drained, so only result backpressure slows the block.
// Reset: arst_n clears the string state and the result valid flag and loads
// the delimiter with 34 (double quote).
module delimited_string_unescaper_top #(
	parameter int unsigned COUNT_MAX = dsu_pkg::COUNT_MAX_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        stream_end,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        finished,
	output logic        failed,
	output logic [15:0] byte_count
);
	import dsu_pkg::*;

	logic [7:0]  delimiter_q;
	dsu_state_t  state_q;
	dsu_state_t  state_next;
	dsu_result_t result_next;
	dsu_result_t result_q;
	logic        result_valid_q;
	logic        accept;

	assign in_ready = !result_valid_q || result_ready;
	assign accept   = in_valid && in_ready;

	dsu_decode #(
		.COUNT_MAX(COUNT_MAX)
	) u_decode (
		.state      (state_q),
		.delimiter  (delimiter_q),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.state_next (state_next),
		.result     (result_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delimiter_q <= DELIM_RESET;
		end else if (cfg_we) begin
			delimiter_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q        <= state_next;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// The result word holds its value until it is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign out_byte     = result_q.out_byte;
	assign out_valid    = result_q.out_valid;
	assign finished     = result_q.finished;
	assign failed       = result_q.failed;
	assign byte_count   = result_q.byte_count;

endmodule
